>>> sv/bptl_pkg.sv
// Package for the breathing triangle PWM level block.
// Shared types, register indexes and widths; used by bptl_cell and the top level.
package bptl_pkg;

    localparam int NUM_BOARDS  = 4;
    localparam int REM_W       = 27;
    localparam int NUM_W       = 40;
    localparam int P1_STEPS    = 32;
    localparam int P2_STEPS    = 25;
    localparam int P3_STEPS    = 40;
    localparam logic [15:0] TRI_FULL = 16'hFFFF;

    typedef enum logic [2:0] {
        REG_BREATH_PERIOD = 3'd0,
        REG_LEVEL_MIN     = 3'd1,
        REG_LEVEL_MAX     = 3'd2,
        REG_PHASE_SHIFT   = 3'd3,
        REG_HOLD_BEFORE   = 3'd4,
        REG_HOLD_AFTER    = 3'd5
    } t_reg_idx;

    // Work item handed from cell to cell.
    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [NUM_W-1:0] num;
        logic [1:0]       board;
        logic [3:0]       chan;
        logic             flat;      // level is forced to the minimum
        logic             fall;      // falling half of the triangle
    } t_item;

endpackage

>>> sv/bptl_cell.sv
// One restoring-division cell: shifts one dividend bit into the remainder.
// Depends on bptl_pkg.
module bptl_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  bptl_pkg::t_item            i_item,
    input  logic [bptl_pkg::REM_W-1:0] i_div,
    output logic                       o_valid,
    output bptl_pkg::t_item            o_item
);

    logic [bptl_pkg::REM_W:0] sh;
    logic                     ge;
    bptl_pkg::t_item          n_item;
    logic                     r_valid;
    bptl_pkg::t_item          r_item;

    always_comb begin
        sh     = {i_item.rem, i_item.num[bptl_pkg::NUM_W-1]};
        ge     = sh >= {1'b0, i_div};
        n_item = i_item;
        n_item.rem = ge ? bptl_pkg::REM_W'(sh - {1'b0, i_div})
                        : sh[bptl_pkg::REM_W-1:0];
        n_item.num = {i_item.num[bptl_pkg::NUM_W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

>>> sv/breathing_triangle_pwm_level.sv
// Top level of the breathing triangle PWM level block.
// Depends on bptl_pkg and bptl_cell.
//
// Usage:
//   Slave stream (s_*) takes one transaction per item: time in ms, board and
//   channel. Master stream (m_*) returns board, channel and the 16-bit level.
//   The APB port holds the six timing and level registers; write them only
//   while no transaction is in flight.
// Throughput: one item per cycle while the output is not stalled. The work
//   is a chain of 97 division cells (cycle modulo, period modulo, triangle
//   divide), one quotient bit per cell, then map stages C to E; all stages move together.
// Reset: synchronous active low; clears all pipeline valid bits and loads
//   the register defaults (period 2000, min 0, max 4095, others 0).
// Stall: while m_tvalid is high and m_tready low the whole chain holds and
//   s_tready drops; it rises again in the cycle m_tready returns.
// Items with a board index at or above the board count produce no result.
module breathing_triangle_pwm_level (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [31:0] time_ms, [33:32] board_index, [37:34] channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [1:0] out_board, [5:2] out_channel, [21:6] level
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // ---------------- configuration ----------------
    logic [23:0] r_period, r_hold_b, r_hold_a;
    logic [15:0] r_min, r_max, r_phase;
    logic        wr;
    logic [2:0]  widx;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign widx   = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= 24'd2000;
            r_min    <= 16'd0;
            r_max    <= 16'd4095;
            r_phase  <= 16'd0;
            r_hold_b <= 24'd0;
            r_hold_a <= 24'd0;
        end else if (wr) begin
            case (widx)
                bptl_pkg::REG_BREATH_PERIOD: r_period <= pwdata[23:0];
                bptl_pkg::REG_LEVEL_MIN:     r_min    <= pwdata[15:0];
                bptl_pkg::REG_LEVEL_MAX:     r_max    <= pwdata[15:0];
                bptl_pkg::REG_PHASE_SHIFT:   r_phase  <= pwdata[15:0];
                bptl_pkg::REG_HOLD_BEFORE:   r_hold_b <= pwdata[23:0];
                bptl_pkg::REG_HOLD_AFTER:    r_hold_a <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (widx)
            bptl_pkg::REG_BREATH_PERIOD: prdata = {8'd0, r_period};
            bptl_pkg::REG_LEVEL_MIN:     prdata = {16'd0, r_min};
            bptl_pkg::REG_LEVEL_MAX:     prdata = {16'd0, r_max};
            bptl_pkg::REG_PHASE_SHIFT:   prdata = {16'd0, r_phase};
            bptl_pkg::REG_HOLD_BEFORE:   prdata = {8'd0, r_hold_b};
            bptl_pkg::REG_HOLD_AFTER:    prdata = {8'd0, r_hold_a};
            default:                     prdata = 32'd0;
        endcase
    end

    // ---------------- derived constants (static while items fly) ----------------
    logic [25:0] cycle_len;
    logic [24:0] breath_end;
    logic [22:0] half;
    logic        degen;

    assign cycle_len  = 26'(r_hold_b) + 26'(r_period) + 26'(r_hold_a);
    assign breath_end = 25'(r_hold_b) + 25'(r_period);
    assign half       = r_period[23:1];
    assign degen      = (cycle_len == 26'd0) || (r_period < 24'd2);

    // ---------------- pipeline control ----------------
    logic en;
    logic r_out_valid;
    assign en       = !r_out_valid || m_tready;
    assign s_tready = en;

    // Stage 0: load cycle modulo
    logic            r_v0;
    bptl_pkg::t_item r_i0;
    logic            board_ok;
    assign board_ok = 32'(s_tdata[33:32]) < 32'(bptl_pkg::NUM_BOARDS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v0 <= 1'b0;
        else if (en)  r_v0 <= s_tvalid && board_ok;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_i0.rem   <= '0;
            r_i0.num   <= {s_tdata[31:0], 8'd0};
            r_i0.board <= s_tdata[33:32];
            r_i0.chan  <= s_tdata[37:34];
            r_i0.flat  <= degen;
            r_i0.fall  <= 1'b0;
        end
    end

    // Phase 1: time modulo cycle
    logic            v1 [0:bptl_pkg::P1_STEPS];
    bptl_pkg::t_item c1 [0:bptl_pkg::P1_STEPS];
    assign v1[0] = r_v0;
    assign c1[0] = r_i0;
    for (genvar k = 0; k < bptl_pkg::P1_STEPS; k++) begin : g_p1
        bptl_cell u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
            .i_valid(v1[k]), .i_item(c1[k]), .i_div(bptl_pkg::REM_W'(cycle_len)),
            .o_valid(v1[k+1]), .o_item(c1[k+1])
        );
    end

    // Stage A: hold test, load period modulo
    logic            r_va;
    bptl_pkg::t_item r_ia;
    bptl_pkg::t_item ld_a;
    logic [25:0]     pos;
    logic [24:0]     bt;

    always_comb begin
        pos  = c1[bptl_pkg::P1_STEPS].rem[25:0];
        bt   = 25'(pos - 26'(r_hold_b) + 26'(r_phase));
        ld_a = c1[bptl_pkg::P1_STEPS];
        ld_a.rem  = '0;
        ld_a.num  = {bt, 15'd0};
        ld_a.flat = c1[bptl_pkg::P1_STEPS].flat || (pos < 26'(r_hold_b))
                    || (pos >= 26'(breath_end));
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_va <= 1'b0;
        else if (en)  r_va <= v1[bptl_pkg::P1_STEPS];
    end
    always_ff @(posedge i_clk) begin
        if (en) r_ia <= ld_a;
    end

    // Phase 2: breath time modulo period
    logic            v2 [0:bptl_pkg::P2_STEPS];
    bptl_pkg::t_item c2 [0:bptl_pkg::P2_STEPS];
    assign v2[0] = r_va;
    assign c2[0] = r_ia;
    for (genvar k = 0; k < bptl_pkg::P2_STEPS; k++) begin : g_p2
        bptl_cell u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
            .i_valid(v2[k]), .i_item(c2[k]), .i_div(bptl_pkg::REM_W'(r_period)),
            .o_valid(v2[k+1]), .o_item(c2[k+1])
        );
    end

    // Stage B: fold into half period, load nh*65535 / half
    logic            r_vb;
    bptl_pkg::t_item r_ib;
    bptl_pkg::t_item ld_b;
    logic [23:0]     ct, nh;
    logic            fall;

    always_comb begin
        ct   = c2[bptl_pkg::P2_STEPS].rem[23:0];
        fall = ct >= 24'(half);
        nh   = fall ? ct - 24'(half) : ct;
        ld_b = c2[bptl_pkg::P2_STEPS];
        ld_b.rem  = '0;
        ld_b.num  = {nh, 16'd0} - 40'(nh);
        ld_b.fall = fall;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vb <= 1'b0;
        else if (en)  r_vb <= v2[bptl_pkg::P2_STEPS];
    end
    always_ff @(posedge i_clk) begin
        if (en) r_ib <= ld_b;
    end

    // Phase 3: triangle divide
    logic            v3 [0:bptl_pkg::P3_STEPS];
    bptl_pkg::t_item c3 [0:bptl_pkg::P3_STEPS];
    assign v3[0] = r_vb;
    assign c3[0] = r_ib;
    for (genvar k = 0; k < bptl_pkg::P3_STEPS; k++) begin : g_p3
        bptl_cell u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
            .i_valid(v3[k]), .i_item(c3[k]), .i_div(bptl_pkg::REM_W'(half)),
            .o_valid(v3[k+1]), .o_item(c3[k+1])
        );
    end

    // Stage C: triangle value, |max-min|
    logic        r_vc, r_flat_c, r_neg_c;
    logic [1:0]  r_board_c;
    logic [3:0]  r_chan_c;
    logic [15:0] r_tri, r_absd;
    logic [15:0] qt;
    assign qt = c3[bptl_pkg::P3_STEPS].num[15:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vc <= 1'b0;
        else if (en)  r_vc <= v3[bptl_pkg::P3_STEPS];
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tri     <= c3[bptl_pkg::P3_STEPS].fall ? bptl_pkg::TRI_FULL - qt : qt;
            r_neg_c   <= r_max < r_min;
            r_absd    <= (r_max < r_min) ? r_min - r_max : r_max - r_min;
            r_flat_c  <= c3[bptl_pkg::P3_STEPS].flat;
            r_board_c <= c3[bptl_pkg::P3_STEPS].board;
            r_chan_c  <= c3[bptl_pkg::P3_STEPS].chan;
        end
    end

    // Stage D: product
    logic        r_vd, r_flat_d, r_neg_d;
    logic [1:0]  r_board_d;
    logic [3:0]  r_chan_d;
    logic [31:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vd <= 1'b0;
        else if (en)  r_vd <= r_vc;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_prod    <= 32'(r_tri) * 32'(r_absd);
            r_neg_d   <= r_neg_c;
            r_flat_d  <= r_flat_c;
            r_board_d <= r_board_c;
            r_chan_d  <= r_chan_c;
        end
    end

    // Stage E: divide by 65535 and offset; output register
    logic [32:0] qsum;
    logic [15:0] q, n_level, r_level;
    logic [1:0]  r_board_o;
    logic [3:0]  r_chan_o;

    always_comb begin
        // floor(x / 65535) = (x + (x >> 16) + 1) >> 16 for x up to 65535*65535, the product range
        qsum = 33'(r_prod) + 33'(r_prod[31:16]) + 33'd1;
        q    = qsum[31:16];
        if (r_flat_d)     n_level = r_min;
        else if (r_neg_d) n_level = r_min - q;
        else              n_level = r_min + q;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out_valid <= 1'b0;
        else if (en)  r_out_valid <= r_vd;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_level   <= n_level;
            r_board_o <= r_board_d;
            r_chan_o  <= r_chan_d;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {2'b00, r_level, r_chan_o, r_board_o};

endmodule

>>> sv/bptl_checker.sv
// Port-level checker for the breathing triangle PWM level block, with bind.
// Depends on breathing_triangle_pwm_level ports only.
module bptl_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        pready
);

    // no result can appear right after reset
    a_reset_clear: assert property (@(posedge i_clk) !i_rst_n |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // input side only backs up when the output side is stalled
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("s_tready does not follow output stall");

    // top padding bits stay zero and pready is high while m_tvalid is high
    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (m_tdata[23:22] == 2'b00) && pready)
        else $error("padding bits or pready wrong");

endmodule

bind breathing_triangle_pwm_level bptl_checker u_bptl_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .pready(pready)
);
